// ===== rtl/iex_pkg.sv =====
// ----------------------------------------------------------------------------
// iex_pkg
// types, opcodes and cycle costs shared by the instruction executor
// ----------------------------------------------------------------------------
package iex_pkg;

  localparam int REG_COUNT = 32;
  localparam int RIDX_W    = $clog2(REG_COUNT);

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_MOV = 5'd1, OP_LOAD = 5'd2, OP_STORE = 5'd3,
    OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7,
    OP_AND = 5'd8, OP_OR = 5'd9, OP_XOR = 5'd10, OP_SHL = 5'd11,
    OP_SHR = 5'd12, OP_CMP = 5'd13, OP_JMP = 5'd14, OP_JCC = 5'd15,
    OP_CALL = 5'd16, OP_RET = 5'd17, OP_VADD = 5'd18, OP_VMUL = 5'd19
  } op_t;

  localparam logic [1:0] SRC_REG = 2'd1;
  localparam logic [1:0] SRC_IMM = 2'd2;

  localparam logic [63:0] COST_ONE  = 64'd1;
  localparam logic [63:0] COST_MUL  = 64'd3;
  localparam logic [63:0] COST_DIV  = 64'd15;
  localparam logic [63:0] COST_VADD = 64'd2;
  localparam logic [63:0] COST_VMUL = 64'd4;

  typedef struct packed {
    logic [4:0]  kind;
    logic        dest_is_reg;
    logic [5:0]  dest_reg;
    logic [1:0]  src1_kind;
    logic [5:0]  src1_reg;
    logic signed [63:0] src1_imm;
    logic [1:0]  src2_kind;
    logic [5:0]  src2_reg;
    logic signed [63:0] src2_imm;
    logic        has_successor;
    logic        first;
  } in_beat_t;

  typedef struct packed {
    logic        wrote;
    logic [4:0]  write_reg;
    logic signed [63:0] write_value;
    logic        jump_taken;
    logic        finished;
    logic [63:0] cycle_total;
  } out_beat_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

endpackage

// ===== rtl/iex_divider.sv =====
// ----------------------------------------------------------------------------
// iex_divider
// signed 64-bit radix-2 restoring divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module iex_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  iex_pkg::div_req_t  req,
  output logic               done,
  output logic [63:0]        quot
);
  import iex_pkg::*;

  logic        busy_r, busy_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] q_r, q_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic        zero_r, zero_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;
  logic [64:0] shifted;

  assign shifted = {rem_r, q_r[63]};
  assign trial   = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'd0;
      q_nxt    = req.num[63] ? (64'd0 - req.num) : req.num;
      den_nxt  = req.den[63] ? (64'd0 - req.den) : req.den;
      rem_nxt  = 64'd0;
      neg_nxt  = req.num[63] ^ req.den[63];
      zero_nxt = (req.den == 64'd0);
    end else if (busy_r) begin
      if (trial[64]) begin
        rem_nxt = shifted[63:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end else begin
        rem_nxt = trial[63:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  assign done = done_r;
  assign quot = zero_r ? 64'd0 : (neg_r ? (64'd0 - q_r) : q_r);

endmodule

// ===== rtl/ir_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// ir_instruction_executor
// executes one instruction per beat against a 64-bit register file
// ----------------------------------------------------------------------------
//  channel | direction | payload     | handshake
//  in_     | input     | in_beat_t   | in_valid / in_stall
//  out_    | output    | out_beat_t  | out_valid / out_stall
//
//  one beat at a time: read state, execute state (mul first steps through a
//  shared 32x32 multiplier, div waits on the radix-2 divider), then result
//  register; writeback happens with the result
//  after reset a clearing pass writes zero to all REG_COUNT register entries
//  while in_stall is high; out_stall holds the result and stalls the input
// ----------------------------------------------------------------------------
module ir_instruction_executor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  iex_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output iex_pkg::out_beat_t out_data
);
  import iex_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001, ST_IDLE = 6'b000010, ST_READ = 6'b000100,
    ST_EXEC  = 6'b001000, ST_MUL  = 6'b010000, ST_DIV  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [63:0] rf [REG_COUNT];
  logic [RIDX_W:0] clr_r, clr_nxt;
  in_beat_t  item_r;
  out_beat_t res_r, res_nxt;
  logic      ovalid_r, ovalid_nxt;
  logic [63:0] cyc_r, cyc_nxt;
  logic [63:0] rd1_r, rd2_r, mul_r, mul_nxt;
  logic [1:0]  mstep_r, mstep_nxt;
  logic [31:0] mop_a, mop_b;
  logic [63:0] mprod;
  logic [63:0] v1, v2, val, cost, base;
  logic        writes, we;
  logic [RIDX_W-1:0] wa;
  logic [63:0] wd;
  logic        dst_ok;
  logic [5:0]  dst;
  div_req_t    dreq;
  logic        ddone;
  logic [63:0] dquot;
  logic        accept;

  iex_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dquot));

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE) || ovalid_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept) begin
      rd1_r <= rf[in_data.src1_reg[RIDX_W-1:0]];
      rd2_r <= rf[in_data.src2_reg[RIDX_W-1:0]];
    end
    if (we) rf[wa] <= wd;
  end

  always_comb begin
    v1 = 64'd0;
    if (item_r.src1_kind == SRC_IMM) v1 = item_r.src1_imm;
    else if (item_r.src1_kind == SRC_REG && item_r.src1_reg < 6'(REG_COUNT)) v1 = rd1_r;
    v2 = 64'd0;
    if (item_r.src2_kind == SRC_IMM) v2 = item_r.src2_imm;
    else if (item_r.src2_kind == SRC_REG && item_r.src2_reg < 6'(REG_COUNT)) v2 = rd2_r;
    dst    = item_r.dest_is_reg ? item_r.dest_reg : 6'd0;
    dst_ok = dst < 6'(REG_COUNT);
  end

  // low 64 bits of the product from three 32x32 partial products
  always_comb begin
    unique case (mstep_r)
      2'd0: begin
        mop_a = v1[31:0];
        mop_b = v2[31:0];
      end
      2'd1: begin
        mop_a = v1[31:0];
        mop_b = v2[63:32];
      end
      default: begin
        mop_a = v1[63:32];
        mop_b = v2[31:0];
      end
    endcase
    mprod = {32'd0, mop_a} * {32'd0, mop_b};
  end

  always_comb begin
    val = 64'd0;
    cost = COST_ONE;
    writes = 1'b1;
    unique case (op_t'(item_r.kind))
      OP_MOV:  val = v1;
      OP_ADD:  val = v1 + v2;
      OP_SUB:  val = v1 - v2;
      OP_MUL:  begin val = mul_r; cost = COST_MUL; end
      OP_DIV:  begin val = dquot; cost = COST_DIV; end
      OP_AND:  val = v1 & v2;
      OP_OR:   val = v1 | v2;
      OP_XOR:  val = v1 ^ v2;
      OP_SHL:  val = v1 << v2[5:0];
      OP_SHR:  val = 64'($signed(v1) >>> v2[5:0]);
      OP_VADD: begin val = v1 + v2; cost = COST_VADD; end
      OP_VMUL: begin val = mul_r; cost = COST_VMUL; end
      default: writes = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    ovalid_nxt = ovalid_r && out_stall;
    res_nxt    = res_r;
    cyc_nxt    = cyc_r;
    mul_nxt    = mul_r;
    mstep_nxt  = mstep_r;
    we         = 1'b0;
    wa         = dst[RIDX_W-1:0];
    wd         = val;
    dreq.start = 1'b0;
    dreq.num   = v1;
    dreq.den   = v2;
    base       = item_r.first ? 64'd0 : cyc_r;
    unique case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        wa = clr_r[RIDX_W-1:0];
        wd = 64'd0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (RIDX_W+1)'(REG_COUNT - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: if (accept) state_nxt = ST_READ;
      ST_READ: begin
        if (item_r.kind == OP_MUL || item_r.kind == OP_VMUL) begin
          mstep_nxt = 2'd0;
          state_nxt = ST_MUL;
        end else if (item_r.kind == OP_DIV) begin
          dreq.start = 1'b1;
          state_nxt  = ST_DIV;
        end else state_nxt = ST_EXEC;
      end
      ST_MUL: begin
        mul_nxt   = (mstep_r == 2'd0) ? mprod : mul_r + {mprod[31:0], 32'd0};
        mstep_nxt = mstep_r + 2'd1;
        if (mstep_r == 2'd2) state_nxt = ST_EXEC;
      end
      ST_DIV: if (ddone) state_nxt = ST_EXEC;
      ST_EXEC: begin
        we = writes && dst_ok;
        cyc_nxt = base + cost;
        res_nxt.wrote       = we;
        res_nxt.write_reg   = we ? dst[4:0] : 5'd0;
        res_nxt.write_value = we ? val : 64'd0;
        res_nxt.jump_taken  = (item_r.kind == OP_JMP) && item_r.has_successor;
        res_nxt.finished    = (item_r.kind == OP_RET);
        res_nxt.cycle_total = cyc_nxt;
        ovalid_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
      cyc_r    <= 64'd0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
      cyc_r    <= cyc_nxt;
    end
    res_r   <= res_nxt;
    mul_r   <= mul_nxt;
    mstep_r <= mstep_nxt;
    if (accept) item_r <= in_data;
  end

  assign out_valid = ovalid_r;
  assign out_data  = res_r;

endmodule

// ===== rtl/iex_checker.sv =====
// ----------------------------------------------------------------------------
// iex_checker
// port-level checks on the instruction executor
// ----------------------------------------------------------------------------
module iex_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input iex_pkg::out_beat_t out_data
);
  import iex_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(in_valid && !in_stall))
    else $error("input taken while result pending");

  a_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.wrote |-> out_data.write_value == 64'd0)
    else $error("value without write");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.wrote && (out_data.finished || out_data.jump_taken)))
    else $error("write with control flow");

endmodule

bind ir_instruction_executor iex_checker u_iex_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for ir_instruction_executor: directed and random
// instructions against a behavioral model of the register file and cycle count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import iex_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  ir_instruction_executor dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  logic [63:0] regs_model [REG_COUNT];
  logic [63:0] cycles_model;
  out_beat_t   pending_results[$];
  int          errors = 0;
  int          idle_pct = 27;
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;
  int          hold_cnt = 0;
  int          quiet_cycles = 0;

  function automatic logic [63:0] operand(logic [1:0] k, logic [5:0] r, logic [63:0] imm);
    if (k == SRC_IMM) return imm;
    if (k == SRC_REG && r < REG_COUNT) return regs_model[r];
    return 64'd0;
  endfunction

  function automatic logic [63:0] quotient(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, q;
    if (b == 64'd0) return 64'd0;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic out_beat_t execute(in_beat_t it);
    out_beat_t   res;
    logic [63:0] a, b, val, cost;
    logic [5:0]  dst;
    bit          writes;
    res = '0;
    a = operand(it.src1_kind, it.src1_reg, it.src1_imm);
    b = operand(it.src2_kind, it.src2_reg, it.src2_imm);
    dst = it.dest_is_reg ? it.dest_reg : 6'd0;
    writes = 1'b1;
    cost = COST_ONE;
    val = 64'd0;
    if (it.first) cycles_model = 64'd0;
    case (it.kind)
      OP_MOV:  val = a;
      OP_ADD:  val = a + b;
      OP_SUB:  val = a - b;
      OP_MUL:  begin val = a * b; cost = COST_MUL; end
      OP_DIV:  begin val = quotient(a, b); cost = COST_DIV; end
      OP_AND:  val = a & b;
      OP_OR:   val = a | b;
      OP_XOR:  val = a ^ b;
      OP_SHL:  val = a << b[5:0];
      OP_SHR:  val = $unsigned($signed(a) >>> b[5:0]);
      OP_VADD: begin val = a + b; cost = COST_VADD; end
      OP_VMUL: begin val = a * b; cost = COST_VMUL; end
      OP_JMP:  begin writes = 1'b0; res.jump_taken = it.has_successor; end
      OP_RET:  begin writes = 1'b0; res.finished = 1'b1; end
      default: writes = 1'b0;
    endcase
    if (writes && dst < REG_COUNT) begin
      regs_model[dst] = val;
      res.wrote = 1'b1;
      res.write_reg = dst[4:0];
      res.write_value = val;
    end
    cycles_model = cycles_model + cost;
    res.cycle_total = cycles_model;
    return res;
  endfunction

  task automatic send_beat(in_beat_t it);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(execute(it));
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return 64'h8000_0000_0000_0000;
      2: return 64'h7fff_ffff_ffff_ffff;
      3: return '1;
      4: return {58'd0, 6'($urandom)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t it;
    it.kind = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(19));
    it.dest_is_reg = ($urandom_range(7) != 0);
    it.dest_reg = ($urandom_range(5) == 0) ? 6'($urandom) : 6'($urandom_range(REG_COUNT - 1));
    it.src1_kind = 2'($urandom);
    it.src1_reg = ($urandom_range(5) == 0) ? 6'($urandom) : 6'($urandom_range(REG_COUNT - 1));
    it.src1_imm = rand64();
    it.src2_kind = 2'($urandom);
    it.src2_reg = ($urandom_range(5) == 0) ? 6'($urandom) : 6'($urandom_range(REG_COUNT - 1));
    it.src2_imm = rand64();
    if (it.kind == OP_DIV && $urandom_range(2) == 0) it.src2_kind = SRC_IMM;
    it.has_successor = 1'($urandom);
    it.first = ($urandom_range(30) == 0);
    return it;
  endfunction

  function automatic in_beat_t make_beat(op_t op, logic [5:0] d, logic [1:0] k1,
                                         logic [63:0] v1, logic [1:0] k2, logic [63:0] v2);
    in_beat_t it;
    it = '0;
    it.kind = op;
    it.dest_is_reg = 1'b1;
    it.dest_reg = d;
    it.src1_kind = k1;
    it.src1_reg = v1[5:0];
    it.src1_imm = v1;
    it.src2_kind = k2;
    it.src2_reg = v2[5:0];
    it.src2_imm = v2;
    it.has_successor = 1'b1;
    return it;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    in_beat_t it;
    it = make_beat(OP_MOV, 6'd1, SRC_IMM, 64'h8000_0000_0000_0000, 2'd0, 64'd0);
    it.first = 1'b1;
    send_beat(it);
    send_beat(make_beat(OP_MOV, 6'd2, SRC_IMM, '1, 2'd0, 64'd0));
    send_beat(make_beat(OP_DIV, 6'd3, SRC_REG, 64'd1, SRC_REG, 64'd2));
    send_beat(make_beat(OP_DIV, 6'd4, SRC_REG, 64'd1, SRC_IMM, 64'd0));
    send_beat(make_beat(OP_DIV, 6'd5, SRC_IMM, -64'sd7, SRC_IMM, 64'd2));
    send_beat(make_beat(OP_ADD, 6'd6, SRC_IMM, 64'h7fff_ffff_ffff_ffff, SRC_IMM, 64'd1));
    send_beat(make_beat(OP_SUB, 6'd7, SRC_REG, 64'd40, SRC_IMM, 64'd1));
    send_beat(make_beat(OP_MUL, 6'd8, SRC_REG, 64'd1, SRC_IMM, '1));
    send_beat(make_beat(OP_AND, 6'd9, SRC_REG, 64'd2, 2'd3, 64'd5));
    send_beat(make_beat(OP_OR, 6'd10, SRC_REG, 64'd1, SRC_IMM, 64'd1));
    send_beat(make_beat(OP_XOR, 6'd11, SRC_REG, 64'd2, SRC_REG, 64'd1));
    send_beat(make_beat(OP_SHL, 6'd12, SRC_IMM, 64'd3, SRC_IMM, 64'h1ff));
    send_beat(make_beat(OP_SHR, 6'd13, SRC_REG, 64'd1, SRC_IMM, 64'd63));
    send_beat(make_beat(OP_SHR, 6'd14, SRC_REG, 64'd1, SRC_IMM, 64'd64));
    send_beat(make_beat(OP_VADD, 6'd31, SRC_REG, 64'd1, SRC_REG, 64'd2));
    send_beat(make_beat(OP_VMUL, 6'd30, SRC_REG, 64'd2, SRC_REG, 64'd2));
    send_beat(make_beat(OP_MOV, 6'd63, SRC_IMM, 64'd5, 2'd0, 64'd0));
    it = make_beat(OP_MOV, 6'd20, SRC_IMM, 64'd9, 2'd0, 64'd0);
    it.dest_is_reg = 1'b0;
    send_beat(it);
    send_beat(make_beat(OP_JMP, 6'd0, 2'd0, 64'd0, 2'd0, 64'd0));
    it = make_beat(OP_JMP, 6'd0, 2'd0, 64'd0, 2'd0, 64'd0);
    it.has_successor = 1'b0;
    send_beat(it);
    send_beat(make_beat(OP_RET, 6'd0, 2'd0, 64'd0, 2'd0, 64'd0));
    send_beat(make_beat(OP_CMP, 6'd1, SRC_REG, 64'd1, SRC_REG, 64'd2));
    send_beat(make_beat(op_t'(5'd31), 6'd1, SRC_REG, 64'd1, SRC_REG, 64'd2));
    send_beat(make_beat(OP_LOAD, 6'd2, SRC_IMM, '1, SRC_IMM, '1));
  endtask

  task automatic test_random(int count);
    repeat (count) send_beat(random_beat());
  endtask

  task automatic test_backpressure();
    hold_req = ~hold_req;
    test_random(40);
    wait_drained();
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    test_random(300);
    idle_pct = 27;
  endtask

  // output side: random stall plus a long forced hold-off
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cnt <= 300;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    out_beat_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected beat: actual %p", $realtime, out_data);
        errors++;
      end else begin
        exp_beat = pending_results.pop_front();
        if (out_data !== exp_beat) begin
          $display("%0t mismatch: expected %p actual %p", $realtime, exp_beat, out_data);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < REG_COUNT; i++) regs_model[i] = 64'd0;
    cycles_model = 64'd0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_drained();
    test_random(700);
    test_backpressure();
    test_no_idle();
    test_random(800);
    wait_drained();
    repeat (100) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/iex_pkg.sv
rtl/iex_divider.sv
rtl/ir_instruction_executor.sv
rtl/iex_checker.sv
tb/tb.sv
